// ----- src/slif_pkg.sv -----
// Shared constants, types and codes for the sorted list insert/find block.
`timescale 1ns / 1ps
`default_nettype none
package slif_pkg;

   localparam int CAPACITY    = 64;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int LINK_W      = $clog2(CAPACITY + 1);
   localparam int VALUE_W     = 32;
   localparam int NODE_W      = VALUE_W + LINK_W;
   localparam int COUNT_OUT_W = 7;

   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [NODE_W-1:0]  node_type;

   // Link value that marks the end of the list.
   localparam link_type END_LINK = LINK_W'(CAPACITY);

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_FIND   = 1'b1;

   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_EVAL    = 4'b0010,
      ST_WR_SLOT = 4'b0100,
      ST_WR_PRED = 4'b1000
   } state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      node_type wr_data;
   } mem_req_type;

endpackage
`default_nettype wire

// ----- src/slif_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module slif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- src/slif_ctrl.sv -----
// List walker: sequences node reads, the ordered splice and the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module slif_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                action,
   input  wire logic signed [slif_pkg::VALUE_W-1:0] value,
   output logic                                     busy,
   output slif_pkg::mem_req_type                    mem_req,
   input  wire slif_pkg::node_type                  rd_data,
   output logic                                     rsp_valid,
   output logic                                     rsp_found,
   output logic                                     rsp_status,
   output logic [slif_pkg::COUNT_OUT_W-1:0]         rsp_entry_count
);

   slif_pkg::state_type state_ff, state_in;
   slif_pkg::link_type  head_ff, head_in;
   slif_pkg::link_type  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                action_ff, action_in;
   slif_pkg::value_type value_ff, value_in;
   slif_pkg::link_type  cur_ff, cur_in;
   logic                at_head_ff, at_head_in;
   slif_pkg::addr_type  prev_idx_ff, prev_idx_in;
   slif_pkg::value_type prev_val_ff, prev_val_in;
   slif_pkg::link_type  wlink_ff, wlink_in;
   logic                pred_wr_ff, pred_wr_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [slif_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   slif_pkg::value_type node_val;
   slif_pkg::link_type  node_link;
   logic                link_ok;
   logic                head_ok;
   logic                is_full;
   slif_pkg::addr_type  slot_addr;

   assign node_val  = rd_data[slif_pkg::VALUE_W-1:0];
   assign node_link = rd_data[slif_pkg::NODE_W-1:slif_pkg::VALUE_W];
   assign link_ok   = node_link < slif_pkg::END_LINK;
   assign head_ok   = head_ff < slif_pkg::END_LINK;
   assign is_full   = count_ff >= slif_pkg::END_LINK;
   assign slot_addr = count_ff[slif_pkg::ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      action_in     = action_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      at_head_in    = at_head_ff;
      prev_idx_in   = prev_idx_ff;
      prev_val_in   = prev_val_ff;
      wlink_in      = wlink_ff;
      pred_wr_in    = pred_wr_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_req       = '0;

      unique case (state_ff)
         slif_pkg::ST_IDLE: begin
            if (start) begin
               action_in     = action;
               value_in      = value;
               cur_in        = head_ff;
               at_head_in    = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_status_in = slif_pkg::STAT_DONE;
               rsp_count_in  = slif_pkg::COUNT_OUT_W'(count_ff);
               if (action == slif_pkg::ACT_INSERT && is_full) begin
                  // drop the insert, report full
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = slif_pkg::STAT_FULL;
               end else if (!head_ok) begin
                  if (action == slif_pkg::ACT_FIND) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     wlink_in   = slif_pkg::END_LINK;
                     pred_wr_in = 1'b0;
                     head_in    = count_ff;
                     state_in   = slif_pkg::ST_WR_SLOT;
                  end
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_ff[slif_pkg::ADDR_W-1:0];
                  state_in        = slif_pkg::ST_EVAL;
               end
            end
         end

         slif_pkg::ST_EVAL: begin
            if (action_ff == slif_pkg::ACT_FIND) begin
               if (node_val == value_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = slif_pkg::ST_IDLE;
               end else if (!link_ok) begin
                  rsp_valid_in = 1'b1;
                  state_in     = slif_pkg::ST_IDLE;
               end else begin
                  cur_in          = node_link;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = node_link[slif_pkg::ADDR_W-1:0];
               end
            end else begin
               if ($signed(node_val) > $signed(value_ff)) begin
                  // splice in front of this node
                  wlink_in = cur_ff;
                  if (at_head_ff) begin
                     head_in    = count_ff;
                     pred_wr_in = 1'b0;
                  end else begin
                     pred_wr_in = 1'b1;
                  end
                  state_in = slif_pkg::ST_WR_SLOT;
               end else if (!link_ok) begin
                  // append after the tail
                  wlink_in    = slif_pkg::END_LINK;
                  pred_wr_in  = 1'b1;
                  prev_idx_in = cur_ff[slif_pkg::ADDR_W-1:0];
                  prev_val_in = node_val;
                  state_in    = slif_pkg::ST_WR_SLOT;
               end else begin
                  prev_idx_in     = cur_ff[slif_pkg::ADDR_W-1:0];
                  prev_val_in     = node_val;
                  at_head_in      = 1'b0;
                  cur_in          = node_link;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = node_link[slif_pkg::ADDR_W-1:0];
               end
            end
         end

         slif_pkg::ST_WR_SLOT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = slot_addr;
            mem_req.wr_data = {wlink_ff, value_ff};
            if (pred_wr_ff) begin
               state_in = slif_pkg::ST_WR_PRED;
            end else begin
               count_in     = count_ff + 1'b1;
               rsp_count_in = slif_pkg::COUNT_OUT_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = slif_pkg::ST_IDLE;
            end
         end

         slif_pkg::ST_WR_PRED: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = prev_idx_ff;
            mem_req.wr_data = {count_ff, prev_val_ff};
            count_in        = count_ff + 1'b1;
            rsp_count_in    = slif_pkg::COUNT_OUT_W'(count_in);
            rsp_valid_in    = 1'b1;
            state_in        = slif_pkg::ST_IDLE;
         end

         default: begin
            state_in = slif_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slif_pkg::ST_IDLE;
         head_ff      <= slif_pkg::END_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      at_head_ff    <= at_head_in;
      prev_idx_ff   <= prev_idx_in;
      prev_val_ff   <= prev_val_in;
      wlink_ff      <= wlink_in;
      pred_wr_ff    <= pred_wr_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = state_ff != slif_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

// ----- src/sorted_list_insert_find.sv -----
// Top level of the sorted list insert/find block: node RAM plus list walker.
//
//   channel   ports                                   handshake
//   request   req_action, req_value                   start && !busy
//   response  rsp_found, rsp_status, rsp_entry_count  rsp_valid, one cycle
//
// A find walks until it hits the value or the tail; an insert walks to its
// place, writes the new slot, then its predecessor unless it goes at the
// head. The node RAM has one read port and the walk follows one link per
// cycle. A full-store insert or an empty-list find answers with no node read.
// Reset empties the list at once; the node RAM needs no clearing pass.
// The receiver cannot stall: rsp_valid is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_insert_find (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_action,
   input  wire logic signed [slif_pkg::VALUE_W-1:0] req_value,
   output logic                                     rsp_valid,
   output logic                                     rsp_found,
   output logic                                     rsp_status,
   output logic [slif_pkg::COUNT_OUT_W-1:0]         rsp_entry_count
);

   slif_pkg::mem_req_type mem_req;
   slif_pkg::node_type    rd_data;

   slif_ram #(
      .WIDTH(slif_pkg::NODE_W),
      .DEPTH(slif_pkg::CAPACITY)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (mem_req.wr_en),
      .wr_addr(mem_req.wr_addr),
      .wr_data(mem_req.wr_data),
      .rd_en  (mem_req.rd_en),
      .rd_addr(mem_req.rd_addr),
      .rd_data(rd_data)
   );

   slif_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .action         (req_action),
      .value          (req_value),
      .busy           (busy),
      .mem_req        (mem_req),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

endmodule
`default_nettype wire

// ----- src/slif_checker.sv -----
// Port-level checks for the sorted list insert/find block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module slif_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_found,
   input wire logic                                rsp_status,
   input wire logic [slif_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);

   // an accepted transaction occupies the block until its response
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // the response is issued as the block goes idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // a dropped insert is never a hit
   a_full_no_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_found)
      else $error("dropped insert reports found");

   // a dropped insert only happens with the store full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_entry_count == slif_pkg::COUNT_OUT_W'(slif_pkg::CAPACITY)))
      else $error("dropped insert with store not full");

endmodule

bind sorted_list_insert_find slif_checker u_slif_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_found      (rsp_found),
   .rsp_status     (rsp_status),
   .rsp_entry_count(rsp_entry_count)
);
`default_nettype wire
